>>> hw/rtl/prac_pkg.sv
// Shared types and constants for the priority resource arbiter with cooldown.
`default_nettype none

package prac_pkg;

    // Key and time width
    localparam int KEY_W = 32;

    // APB register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_DEADLINE_MODE = 2'd0;
    localparam logic [1:0] REG_BURNOUT_TIME  = 2'd1;
    localparam logic [1:0] REG_COOLDOWN_TIME = 2'd2;

    // Transaction kinds on the input channel
    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } prac_state_t;

    // Configuration registers
    typedef struct packed {
        logic             deadline_mode;
        logic [KEY_W-1:0] burnout_time;
        logic [KEY_W-1:0] cooldown_time;
    } prac_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_step;
        logic shift_rd;
        logic shift_wr;
        logic finish;
        logic load_out;
    } prac_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic grant_ok;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } prac_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/priority_resource_arbiter_cooldown.sv
// Top level of the priority resource arbiter with cooldown: APB registers, controller, datapath.
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: req_type selects
//   enqueue a requester, release the resource, or advance the millisecond clock.
//   Output channel (out_valid/out_ready) returns exactly one result per input transaction:
//   grant_valid/granted_id when the resource went to the best queued entry, and
//   queue_overflow when an enqueue found the queue full and was dropped.
//   The APB port holds deadline_mode (0x0), burnout_time (0x4) and cooldown_time (0x8);
//   write it only while the block is idle.
// Sequencing:
//   Without a grant an accepted item passes through the check and response states into the
//   output register, and the next item is accepted the cycle after the result is loaded.
//   With a grant the check is followed by a search that reads one entry per cycle and a
//   compaction that moves each entry behind the winner with a read state on the single
//   read port and a write state on the write port of the queue RAM.
// Reset clears the queue fill count, clocks, ticket counter and busy flag; queue
//   contents need no clearing. If the receiver stalls, the result stays in the output
//   register and the block holds the following item in its response state.
`default_nettype none

module priority_resource_arbiter_cooldown #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // APB configuration port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [prac_pkg::ADDR_W-1:0]    paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Input channel
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [1:0]                     req_type,
    input  wire  [ID_BITS-1:0]             requester_id,
    input  wire  [prac_pkg::KEY_W-1:0]     last_active_time,
    // Output channel
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic                           grant_valid,
    output logic [ID_BITS-1:0]             granted_id,
    output logic                           queue_overflow
);
    import prac_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic             mode_reg;
    logic [KEY_W-1:0] burnout_reg;
    logic [KEY_W-1:0] cooldown_reg;
    logic [1:0]       reg_index;
    logic             apb_write;

    prac_cfg_t        cfg;
    prac_cmd_t        cmd;
    prac_status_t     status;
    logic [CW-1:0]    q_count;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign apb_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            burnout_reg  <= '0;
            cooldown_reg <= '0;
        end
        else if (apb_write)
        begin
            case (reg_index)
                REG_DEADLINE_MODE: mode_reg     <= pwdata[0];
                REG_BURNOUT_TIME:  burnout_reg  <= pwdata;
                REG_COOLDOWN_TIME: cooldown_reg <= pwdata;
                default:           mode_reg     <= mode_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_index)
            REG_DEADLINE_MODE: prdata = {31'd0, mode_reg};
            REG_BURNOUT_TIME:  prdata = burnout_reg;
            REG_COOLDOWN_TIME: prdata = cooldown_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg = '{
        deadline_mode: mode_reg,
        burnout_time:  burnout_reg,
        cooldown_time: cooldown_reg
    };

    prac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    prac_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .req_type         (req_type),
        .requester_id     (requester_id),
        .last_active_time (last_active_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .grant_valid      (grant_valid),
        .granted_id       (granted_id),
        .queue_overflow   (queue_overflow),
        .q_count          (q_count)
    );

    // An accepted transaction occupies the block, so in_ready is low after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous transaction in progress");

    // Queue fill never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // A result without a grant reports id zero
    a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !grant_valid) |-> (granted_id == '0))
        else $error("granted id nonzero without grant");

endmodule

`default_nettype wire

>>> hw/rtl/prac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prac_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/prac_ctrl.sv
// Sequencing state machine for the arbiter: accept, grant check, scan, compaction, response.
`default_nettype none

module prac_ctrl (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire prac_pkg::prac_status_t  status,
    output prac_pkg::prac_cmd_t          cmd
);
    import prac_pkg::*;

    prac_state_t state_reg;
    prac_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.grant_ok ? ST_SCAN : ST_RESP;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = status.shift_done ? ST_RESP : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_CHECK:
            begin
                cmd.scan_start = status.grant_ok;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_SHIFT_RD:
            begin
                cmd.shift_rd = !status.shift_done;
                cmd.finish   = status.shift_done;
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
            end
            ST_RESP:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/prac_dp.sv
// Arbiter datapath: queue storage, key formation, minimum search, compaction and output register.
`default_nettype none

module prac_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire prac_pkg::prac_cfg_t              cfg,
    input  wire prac_pkg::prac_cmd_t              cmd,
    output prac_pkg::prac_status_t                status,
    input  wire  [1:0]                            req_type,
    input  wire  [ID_BITS-1:0]                    requester_id,
    input  wire  [prac_pkg::KEY_W-1:0]            last_active_time,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic                                  grant_valid,
    output logic [ID_BITS-1:0]                    granted_id,
    output logic                                  queue_overflow,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      q_count
);
    import prac_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = AW + 1;
    localparam int EW = ID_BITS + KEY_W;

    // Control registers
    logic [CW-1:0]     count_reg,      count_next;
    logic [KEY_W-1:0]  ticket_reg,     ticket_next;
    logic [KEY_W-1:0]  cur_time_reg,   cur_time_next;
    logic [KEY_W-1:0]  free_time_reg,  free_time_next;
    logic              busy_reg,       busy_next;
    logic              out_valid_reg,  out_valid_next;

    // Payload registers
    logic              ovf_reg,        ovf_next;
    logic              granted_reg,    granted_next;
    logic [AW-1:0]     scan_reg,       scan_next;
    logic [AW-1:0]     pos_reg,        pos_next;
    logic [KEY_W-1:0]  best_key_reg,   best_key_next;
    logic [ID_BITS-1:0] best_id_reg,   best_id_next;
    logic              grant_out_reg,  grant_out_next;
    logic [ID_BITS-1:0] id_out_reg,    id_out_next;
    logic              ovf_out_reg,    ovf_out_next;

    // RAM port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [ID_BITS-1:0] rd_id;

    logic [KEY_W-1:0]  new_key;
    logic              queue_full;
    logic [XW-1:0]     pos_inc;
    logic [XW-1:0]     count_ext;

    assign rd_key     = ram_rdata[KEY_W-1:0];
    assign rd_id      = ram_rdata[EW-1:KEY_W];
    assign queue_full = (count_reg == CW'(QUEUE_DEPTH));
    assign new_key    = cfg.deadline_mode ? (last_active_time + cfg.burnout_time) : ticket_reg;
    assign pos_inc    = XW'(pos_reg) + XW'(1);
    assign count_ext  = XW'(count_reg);

    // Status to controller
    assign status = '{
        grant_ok:   !busy_reg && (count_reg != '0) && (cur_time_reg >= free_time_reg),
        scan_last:  (XW'(scan_reg) + XW'(1)) == count_ext,
        shift_done: (pos_inc >= count_ext),
        out_free:   !out_valid_reg || out_ready
    };

    // Queue storage: {id, key} per entry
    prac_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM write and read address selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {requester_id, new_key};
        if (cmd.accept && (req_type == REQ_ENQUEUE) && !queue_full)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.shift_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = ram_rdata;
        end

        if (cmd.shift_rd)
        begin
            ram_raddr = pos_inc[AW-1:0];
        end
        else if (cmd.scan_step)
        begin
            ram_raddr = scan_reg + AW'(1);
        end
        else
        begin
            ram_raddr = '0;
        end
    end

    // Next-state logic
    always_comb
    begin
        count_next     = count_reg;
        ticket_next    = ticket_reg;
        cur_time_next  = cur_time_reg;
        free_time_next = free_time_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        ovf_next       = ovf_reg;
        granted_next   = granted_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        best_key_next  = best_key_reg;
        best_id_next   = best_id_reg;
        grant_out_next = grant_out_reg;
        id_out_next    = id_out_reg;
        ovf_out_next   = ovf_out_reg;

        // Apply the accepted transaction
        if (cmd.accept)
        begin
            ovf_next     = 1'b0;
            granted_next = 1'b0;
            case (req_type)
                REQ_ENQUEUE:
                begin
                    if (!cfg.deadline_mode)
                    begin
                        ticket_next = ticket_reg + KEY_W'(1);
                    end
                    if (queue_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_RELEASE:
                begin
                    busy_next      = 1'b0;
                    free_time_next = cur_time_reg + cfg.cooldown_time;
                end
                REQ_TICK:
                begin
                    cur_time_next = cur_time_reg + KEY_W'(1);
                end
                default:
                begin
                    ovf_next = 1'b0;
                end
            endcase
        end

        // Minimum search, earliest entry wins a tie
        if (cmd.scan_start)
        begin
            scan_next = '0;
        end
        if (cmd.scan_step)
        begin
            scan_next = scan_reg + AW'(1);
            if ((scan_reg == '0) || (rd_key < best_key_reg))
            begin
                best_key_next = rd_key;
                best_id_next  = rd_id;
                pos_next      = scan_reg;
            end
        end

        // Compaction step
        if (cmd.shift_wr)
        begin
            pos_next = pos_inc[AW-1:0];
        end

        // Grant completes
        if (cmd.finish)
        begin
            count_next   = count_reg - CW'(1);
            busy_next    = 1'b1;
            granted_next = 1'b1;
        end

        // Output register
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            grant_out_next = granted_reg;
            id_out_next    = granted_reg ? best_id_reg : '0;
            ovf_out_next   = ovf_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ticket_reg    <= '0;
            cur_time_reg  <= '0;
            free_time_reg <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ticket_reg    <= ticket_next;
            cur_time_reg  <= cur_time_next;
            free_time_reg <= free_time_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ovf_reg       <= ovf_next;
        granted_reg   <= granted_next;
        scan_reg      <= scan_next;
        pos_reg       <= pos_next;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        grant_out_reg <= grant_out_next;
        id_out_reg    <= id_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign grant_valid    = grant_out_reg;
    assign granted_id     = id_out_reg;
    assign queue_overflow = ovf_out_reg;
    assign q_count        = count_reg;

endmodule

`default_nettype wire
